FILE: rtl/dtus_pkg.sv
// shared types, constants and helper functions for the date to unix seconds block
`default_nettype none

package dtus_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 56;

  localparam logic [11:0] YearBase    = 12'd2000;
  localparam logic [15:0] DaysPerYear = 16'd365;
  localparam logic [16:0] SecsPerHour = 17'd3600;
  localparam logic [16:0] SecsPerMin  = 17'd60;
  localparam logic [32:0] SecsPerDay  = 33'd86400;
  localparam logic [31:0] EpochOffset = 32'd946684800;
  localparam logic [16:0] WeekdayBias = 17'd6;

  // day count and seconds of day handed from front to back
  typedef struct packed {
    logic [15:0] day_count;
    logic [16:0] tod;
  } dtus_entry_t;

  // days of all months before the given one, month above twelve counts as december
  function automatic logic [8:0] cum_days(input logic [3:0] month);
    logic [8:0] r;
    unique case (month)
      4'd0, 4'd1: r = 9'd0;
      4'd2:       r = 9'd31;
      4'd3:       r = 9'd59;
      4'd4:       r = 9'd90;
      4'd5:       r = 9'd120;
      4'd6:       r = 9'd151;
      4'd7:       r = 9'd181;
      4'd8:       r = 9'd212;
      4'd9:       r = 9'd243;
      4'd10:      r = 9'd273;
      4'd11:      r = 9'd304;
      default:    r = 9'd334;
    endcase
    return r;
  endfunction

  // remainder by seven through octal digit folding
  function automatic logic [2:0] mod7(input logic [16:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
       + 6'(v[16:15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = s2[2:0] + 3'(s2[3]);
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dtus_front.sv
// front stage: unpacks the date beat and registers day count and seconds of day
`default_nettype none

module dtus_front
  import dtus_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [InDataW-1:0] in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output dtus_entry_t             out_entry_o
);

  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [11:0] y;
  logic [12:0] y_plus3;
  logic        leap_day;
  dtus_entry_t entry;

  logic        vld_q, vld_d;
  dtus_entry_t entry_q;

  assign year   = in_data_i[11:0];
  assign month  = in_data_i[15:12];
  assign day    = in_data_i[20:16];
  assign hour   = in_data_i[25:21];
  assign minute = in_data_i[31:26];
  assign second = in_data_i[37:32];

  always_comb begin
    y        = (year >= YearBase) ? (year - YearBase) : year;
    y_plus3  = {1'b0, y} + 13'd3;
    leap_day = (month > 4'd2) && (y[1:0] == 2'b00);
    entry.day_count = 16'(day) + 16'(cum_days(month)) + 16'(leap_day)
                    + 16'(16'(y) * DaysPerYear) + 16'(y_plus3[12:2]) - 16'd1;
    entry.tod = 17'(17'(hour) * SecsPerHour) + 17'(17'(minute) * SecsPerMin)
              + 17'(second);
  end

  assign in_ready_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (in_ready_o) begin
      vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      entry_q <= entry;
    end
  end

  assign out_valid_o = vld_q;
  assign out_entry_o = entry_q;

endmodule

`default_nettype wire

FILE: rtl/dtus_fifo.sv
// short queue between front and back stages
`default_nettype none

module dtus_fifo
  import dtus_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire dtus_entry_t in_entry_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output dtus_entry_t      out_entry_o
);

  dtus_entry_t         mem_q [FifoDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push, pop;

  assign in_ready_o  = (cnt_q != CntW'(FifoDepth));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop  ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_entry_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dtus_back.sv
// back stage: unix seconds, day count and weekday into the output register
`default_nettype none

module dtus_back
  import dtus_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire dtus_entry_t         in_entry_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [OutDataW-1:0]      out_data_o
);

  logic [32:0]         prod;
  logic [31:0]         secs;
  logic [2:0]          weekday;
  logic                vld_q, vld_d;
  logic [OutDataW-1:0] data_q;

  always_comb begin
    prod    = 33'(in_entry_i.day_count) * SecsPerDay;
    secs    = prod[31:0] + 32'(in_entry_i.tod) + EpochOffset;
    weekday = mod7({1'b0, in_entry_i.day_count} + WeekdayBias);
  end

  assign in_ready_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (in_ready_o) begin
      vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= {5'd0, weekday, in_entry_i.day_count, secs};
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/date_to_unix_seconds.sv
// top level of the calendar date to unix seconds converter
//
// one beat on the slave stream carries a date and time of day; one beat on
// the master stream returns unix seconds, the day count since 2000-01-01 and
// the weekday for it, in the same order as the inputs
// a beat may be accepted every cycle while the receiver keeps taking results;
// each result passes through the front register, the four-entry queue and
// the output register, in that order, before it shows on m_axis_tvalid
// the back stage carries one 16 by 17 bit constant multiply and the front
// a 12 by 9 bit one beside the hour and minute multiplies, each feeding a register
// a stalled receiver fills the output register and then the queue; the slave
// side keeps taking beats until the queue and the front register are full,
// and the output beat holds steady until taken
// reset clears all valid flags and queue pointers; no beat is lost or repeated
// input fields are not range checked; day count wraps at 16 bits and seconds
// at 32 bits
`default_nettype none

module date_to_unix_seconds
  import dtus_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26], second[37:32]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // unix_seconds[31:0], day_count[47:32], weekday[50:48]
  output logic [OutDataW-1:0]      m_axis_tdata
);

  logic        front_valid, front_ready;
  dtus_entry_t front_entry;
  logic        fifo_valid, fifo_ready;
  dtus_entry_t fifo_entry;

  dtus_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_entry_o (front_entry)
  );

  dtus_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_entry_i  (front_entry),
    .out_valid_o (fifo_valid),
    .out_ready_i (fifo_ready),
    .out_entry_o (fifo_entry)
  );

  dtus_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fifo_valid),
    .in_ready_o  (fifo_ready),
    .in_entry_i  (fifo_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: rtl/dtus_checker.sv
// port level checks for the date to unix seconds block, bound to the top level
`default_nettype none

module dtus_checker
  import dtus_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic [InDataW-1:0]  s_axis_tdata,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  // no result pending once a reset cycle has passed
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  // stalled output beat holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  // weekday lies in sunday to saturday
  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[50:48] != 3'd7)
    else $error("weekday out of range");

  // padding bits above the weekday stay clear
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:51] == '0)
    else $error("output padding not zero");

endmodule

bind date_to_unix_seconds dtus_checker u_dtus_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: test/tb_top.sv
// testbench for date_to_unix_seconds: streamed dates checked against a built-in timestamp predictor
`timescale 1ns / 1ps

module tb_top;
  import dtus_pkg::*;

  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned TailCycles = 10;
  localparam logic [31:0] EpochSecs  = 32'd946684800;
  localparam logic [31:0] BaseYear   = 32'd2000;
  localparam int unsigned MonthLen [0:10] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30};

  // first member ends up in the highest bits, so year sits at bit 0
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } date_t;

  typedef struct packed {
    logic [2:0]  weekday;
    logic [15:0] day_count;
    logic [31:0] unix_seconds;
  } stamp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  wire logic           s_axis_tready;
  // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26], second[37:32]
  logic [InDataW-1:0]  s_axis_tdata = '0;
  wire logic           m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // unix_seconds[31:0], day_count[47:32], weekday[50:48]
  wire logic [OutDataW-1:0] m_axis_tdata;

  stamp_t      expected_stamps [$];
  stamp_t      got_stamp;
  stamp_t      want_stamp;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  date_to_unix_seconds dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic stamp_t predict_stamp(input date_t d);
    logic [31:0] yoff;
    logic [31:0] total;
    logic [31:0] secs;
    logic [15:0] days;
    int unsigned last;
    stamp_t      r;
    yoff = (32'(d.year) >= BaseYear) ? 32'(d.year) - BaseYear : 32'(d.year);
    total = 32'(d.day);
    last = (d.month > 4'd12) ? 12 : int'(d.month);
    for (int m = 1; m < last; m++) total += 32'(MonthLen[m-1]);
    if (d.month > 4'd2 && yoff[1:0] == 2'b00) total += 32'd1;
    total = total + 32'd365 * yoff + (yoff + 32'd3) / 32'd4 - 32'd1;
    days = total[15:0];
    secs = 32'(days) * 32'd24 + 32'(d.hour);
    secs = secs * 32'd60 + 32'(d.minute);
    secs = secs * 32'd60 + 32'(d.second);
    r.unix_seconds = secs + EpochSecs;
    r.day_count = days;
    r.weekday = 3'((32'(days) + 32'd6) % 32'd7);
    return r;
  endfunction

  function automatic date_t mk_date(input int unsigned y, mo, dd, h, mi, s);
    date_t d;
    d.year = 12'(y);
    d.month = 4'(mo);
    d.day = 5'(dd);
    d.hour = 5'(h);
    d.minute = 6'(mi);
    d.second = 6'(s);
    return d;
  endfunction

  function automatic date_t valid_date();
    int unsigned y;
    int unsigned mo;
    int unsigned len;
    y = $urandom_range(2099, 2000);
    mo = $urandom_range(12, 1);
    len = (mo == 12) ? 31 : MonthLen[mo-1];
    if (mo == 2 && (y % 4) == 0) len = 29;
    return mk_date(y, mo, $urandom_range(len, 1), $urandom_range(23, 0),
                   $urandom_range(59, 0), $urandom_range(59, 0));
  endfunction

  function automatic date_t noise_date();
    return date_t'($urandom());
  endfunction

  task automatic send_date(input date_t d);
    while ($urandom_range(99, 0) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= InDataW'(d);
    do @(posedge clk_i); while (!s_axis_tready);
    expected_stamps.push_back(predict_stamp(d));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_stamps.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned n, gap_pct, stall);
    send_gap_pct = gap_pct;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99, 0) < 75) send_date(valid_date());
      else send_date(noise_date());
    end
    drain_results();
  endtask

  task automatic test_directed();
    date_t list [$];
    send_gap_pct = 0;
    stall_pct = 0;
    list.push_back(mk_date(2000, 1, 1, 0, 0, 0));
    list.push_back(mk_date(2099, 12, 31, 23, 59, 59));
    list.push_back(mk_date(2000, 1, 0, 0, 0, 0));
    list.push_back(mk_date(2000, 2, 29, 12, 0, 0));
    list.push_back(mk_date(2000, 3, 1, 0, 0, 1));
    list.push_back(mk_date(2024, 2, 29, 6, 30, 0));
    list.push_back(mk_date(2024, 3, 1, 0, 0, 0));
    list.push_back(mk_date(2023, 3, 1, 0, 0, 0));
    list.push_back(mk_date(2001, 1, 1, 0, 0, 0));
    list.push_back(mk_date(2003, 1, 1, 0, 0, 0));
    list.push_back(mk_date(2024, 0, 15, 8, 8, 8));
    list.push_back(mk_date(2024, 13, 1, 1, 2, 3));
    list.push_back(mk_date(2023, 15, 31, 4, 5, 6));
    list.push_back(mk_date(1999, 6, 15, 10, 20, 30));
    list.push_back(mk_date(0, 1, 1, 0, 0, 0));
    list.push_back(mk_date(0, 0, 0, 0, 0, 0));
    list.push_back(mk_date(4095, 15, 31, 31, 63, 63));
    list.push_back(mk_date(2100, 3, 1, 0, 0, 0));
    list.push_back(mk_date(2001, 2, 31, 0, 0, 0));
    list.push_back(mk_date(2050, 7, 4, 31, 63, 63));
    list.push_back(mk_date(2180, 12, 31, 23, 59, 59));
    foreach (list[i]) send_date(list[i]);
    drain_results();
  endtask

  task automatic test_full_rate();
    run_random(250, 0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random(250, 64, 0);
  endtask

  task automatic test_receiver_stalls();
    run_random(250, 0, 64);
  endtask

  task automatic test_both_gaps();
    run_random(250, 22, 22);
  endtask

  // receiver holds off while beats keep coming, so the block fills and stalls its input
  task automatic test_long_hold_off();
    hold_req <= ~hold_req;
    run_random(100, 0, 0);
  endtask

  // sender waits for every result between short bursts
  task automatic test_pause_and_resume();
    for (int b = 0; b < 5; b++) run_random(10, 10, 30);
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_stamp = stamp_t'(m_axis_tdata[$bits(stamp_t)-1:0]);
      if (expected_stamps.size() == 0) begin
        $error("result beat with nothing expected: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want_stamp = expected_stamps.pop_front();
        if (got_stamp.unix_seconds !== want_stamp.unix_seconds) begin
          $error("unix_seconds: expected %0d, got %0d", want_stamp.unix_seconds,
                 got_stamp.unix_seconds);
          fail_count++;
        end
        if (got_stamp.day_count !== want_stamp.day_count) begin
          $error("day_count: expected %0d, got %0d", want_stamp.day_count,
                 got_stamp.day_count);
          fail_count++;
        end
        if (got_stamp.weekday !== want_stamp.weekday) begin
          $error("weekday: expected %0d, got %0d", want_stamp.weekday, got_stamp.weekday);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_rate();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_gaps();
    test_long_hold_off();
    test_pause_and_resume();
    stall_pct = 0;
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && expected_stamps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
